// ----- rtl/tdm_pkg.sv -----
// Package of the table-driven DFA matcher: transaction types, opcodes,
// register indexes and table entry layout. No dependencies.
`default_nettype none

package tdm_pkg;

	localparam logic [1:0] OP_WRITE  = 2'd0;
	localparam logic [1:0] OP_SYMBOL = 2'd1;
	localparam logic [1:0] OP_END    = 2'd2;

	localparam logic CFG_INITIAL = 1'b0;
	localparam logic CFG_FINAL   = 1'b1;

	localparam int unsigned CFG_DATA_W = 16;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] symbol;
		logic       last;
		logic [3:0] from_state;
		logic [3:0] to_state;
		logic       entry_valid;
	} in_t;

	typedef struct packed {
		logic       accepted;
		logic [3:0] end_state;
		logic       no_transition;
	} out_t;

	typedef struct packed {
		logic       valid;
		logic [3:0] next;
	} entry_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] symbol;
		logic       last;
		logic [3:0] row;
		entry_t     entry;
	} cmd_t;

endpackage

`default_nettype wire

// ----- rtl/table_driven_dfa_matcher.sv -----
// Top level of the table-driven DFA matcher: configuration registers,
// front part, command queue, back part and result queue.
// Depends on tdm_pkg, tdm_fifo, tdm_front and tdm_back.
//
// channel  | signals                        | direction | transaction
// ---------+--------------------------------+-----------+--------------------------
// input    | push, full, item               | in        | push && !full
// result   | empty, pop, result             | out       | pop && !empty
// config   | cfg_we, cfg_index, cfg_data    | in        | cfg_we
//
// One input item per cycle while full is low; a symbol step reads the table once, and the
// registered entry feeds the next table address directly.
// A string end passes the command queue and the step registers before the result queue.
// After reset a clearing pass over all min(NUM_STATES,16) << SYMBOL_BITS table
// entries (4096 by default) holds full high.
// A full result queue stalls the back part; input stays open until the
// two-entry command queue fills.
`default_nettype none

module table_driven_dfa_matcher
	import tdm_pkg::*;
#(
	parameter int unsigned NUM_STATES  = 16,
	parameter int unsigned SYMBOL_BITS = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	output logic                       full,
	input  wire in_t                   item,
	output logic                       empty,
	input  wire logic                  pop,
	output out_t                       result,
	input  wire logic                  cfg_we,
	input  wire logic                  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic [3:0]  initial_q;
	logic [15:0] final_mask_q;

	logic cmd_push;
	cmd_t cmd_in;
	logic cmdq_full;
	logic cmdq_empty;
	cmd_t cmd_out;
	logic cmd_pop;
	logic clearing;
	logic res_push;
	out_t res;
	logic resq_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_q    <= 4'd0;
			final_mask_q <= 16'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_INITIAL: initial_q    <= cfg_data[3:0];
				CFG_FINAL:   final_mask_q <= cfg_data[15:0];
				default:     ;
			endcase
		end
	end

	tdm_front #(
		.NUM_STATES(NUM_STATES)
	) u_front (
		.push      (push),
		.item      (item),
		.full      (full),
		.cmdq_full (cmdq_full),
		.clearing  (clearing),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in)
	);

	tdm_fifo #(
		.WIDTH($bits(cmd_t)),
		.DEPTH(2)
	) u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cmd_push),
		.wdata  (cmd_in),
		.rd     (cmd_pop),
		.rdata  (cmd_out),
		.full   (cmdq_full),
		.empty  (cmdq_empty)
	);

	tdm_back #(
		.NUM_STATES(NUM_STATES),
		.SYMBOL_BITS(SYMBOL_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_avail  (!cmdq_empty),
		.cmd        (cmd_out),
		.cmd_pop    (cmd_pop),
		.init_state (initial_q),
		.final_mask (final_mask_q),
		.clearing   (clearing),
		.res_push   (res_push),
		.res        (res),
		.res_full   (resq_full)
	);

	tdm_fifo #(
		.WIDTH($bits(out_t)),
		.DEPTH(2)
	) u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (res_push),
		.wdata  (res),
		.rd     (pop),
		.rdata  (result),
		.full   (resq_full),
		.empty  (empty)
	);

endmodule

`default_nettype wire

// ----- rtl/tdm_fifo.sv -----
// Small register queue used between the front and back parts and on the
// result side. No package dependencies.
`default_nettype none

module tdm_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             rd,
	output logic      [WIDTH-1:0] rdata,
	output logic                  full,
	output logic                  empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/tdm_front.sv -----
// Front part of the DFA matcher: accepts input transactions, drops those
// without effect and packs the rest into commands. Depends on tdm_pkg.
`default_nettype none

module tdm_front
	import tdm_pkg::*;
#(
	parameter int unsigned NUM_STATES = 16
) (
	input  wire logic push,
	input  wire in_t  item,
	output logic      full,
	input  wire logic cmdq_full,
	input  wire logic clearing,
	output logic      cmd_push,
	output cmd_t      cmd
);

	logic keep;

	assign full = cmdq_full || clearing;

	always_comb begin
		keep = 1'b0;
		unique case (item.opcode)
			OP_WRITE:  keep = (32'(item.from_state) < NUM_STATES);
			OP_SYMBOL: keep = 1'b1;
			OP_END:    keep = 1'b1;
			default:   keep = 1'b0;
		endcase
	end

	always_comb begin
		cmd.kind        = item.opcode;
		cmd.symbol      = item.symbol;
		cmd.last        = item.last;
		cmd.row         = item.from_state;
		cmd.entry.valid = item.entry_valid;
		cmd.entry.next  = item.entry_valid ? item.to_state : 4'd0;
	end

	assign cmd_push = push && !full && keep;

endmodule

`default_nettype wire

// ----- rtl/tdm_back.sv -----
// Back part of the DFA matcher: transition table memory with its clearing
// pass, state stepping and string end reporting. Depends on tdm_pkg.
`default_nettype none

module tdm_back
	import tdm_pkg::*;
#(
	parameter int unsigned NUM_STATES  = 16,
	parameter int unsigned SYMBOL_BITS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cmd_avail,
	input  wire cmd_t        cmd,
	output logic             cmd_pop,
	input  wire logic [3:0]  init_state,
	input  wire logic [15:0] final_mask,
	output logic             clearing,
	output logic             res_push,
	output out_t             res,
	input  wire logic        res_full
);

	localparam int unsigned ROWS  = (NUM_STATES < 16) ? NUM_STATES : 16;
	localparam int unsigned RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int unsigned AW    = RW + SYMBOL_BITS;
	localparam int unsigned DEPTH = ROWS << SYMBOL_BITS;

	entry_t        mem [DEPTH];
	entry_t        rd_q;
	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;

	logic [3:0] cur_q;
	logic       dead_q;
	logic       started_q;

	logic       valid_s2;
	logic       sym_s2;
	logic [3:0] st_s2;
	logic       skip_s2;
	logic       dead_s2;
	logic       finish_s2;

	logic       hit;
	logic [3:0] new_state;
	logic       new_dead;
	logic       stall_s2;
	logic [3:0] eff_cur;
	logic       eff_dead;
	logic       eff_started;
	logic [3:0] st_in;
	logic       oob;
	logic       is_write;
	logic       is_step;
	logic       we;
	logic [AW-1:0] waddr;
	entry_t     wdata;
	logic       rd_en;
	logic [AW-1:0] raddr;

	assign clearing = clr_busy_q;

	always_comb begin
		hit       = sym_s2 && !skip_s2 && rd_q.valid;
		new_state = hit ? rd_q.next : st_s2;
		new_dead  = dead_s2 || (sym_s2 && !hit);
		stall_s2  = valid_s2 && finish_s2 && res_full;
		if (valid_s2) begin
			eff_cur     = new_state;
			eff_dead    = finish_s2 ? 1'b0 : new_dead;
			eff_started = !finish_s2;
		end else begin
			eff_cur     = cur_q;
			eff_dead    = dead_q;
			eff_started = started_q;
		end
	end

	assign res_push          = valid_s2 && finish_s2 && !res_full;
	assign res.accepted      = !new_dead && final_mask[new_state];
	assign res.end_state     = new_state;
	assign res.no_transition = new_dead;

	assign cmd_pop  = cmd_avail && !clr_busy_q && !stall_s2;
	assign is_write = cmd_pop && (cmd.kind == OP_WRITE);
	assign is_step  = cmd_pop && (cmd.kind != OP_WRITE);
	assign st_in    = eff_started ? eff_cur : init_state;
	assign oob      = !(32'(st_in) < NUM_STATES);

	assign rd_en = is_step && (cmd.kind == OP_SYMBOL) && !oob;
	assign raddr = {st_in[RW-1:0], cmd.symbol[SYMBOL_BITS-1:0]};
	assign we    = clr_busy_q || is_write;
	assign waddr = clr_busy_q ? clr_addr_q : {cmd.row[RW-1:0], cmd.symbol[SYMBOL_BITS-1:0]};
	assign wdata = clr_busy_q ? entry_t'('0) : cmd.entry;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rd_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_step) begin
			sym_s2    <= (cmd.kind == OP_SYMBOL);
			st_s2     <= st_in;
			skip_s2   <= eff_dead || oob;
			dead_s2   <= eff_dead;
			finish_s2 <= (cmd.kind == OP_END) || cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2  <= 1'b0;
			cur_q     <= 4'd0;
			dead_q    <= 1'b0;
			started_q <= 1'b0;
		end else begin
			if (!stall_s2) begin
				valid_s2  <= is_step;
				cur_q     <= eff_cur;
				dead_q    <= eff_dead;
				started_q <= eff_started;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/tdm_checker.sv -----
// Port-level checks for the DFA matcher and their bind to the top level.
// Depends on tdm_pkg and table_driven_dfa_matcher.
`default_nettype none

module tdm_checker
	import tdm_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic full,
	input wire logic empty,
	input wire logic pop,
	input wire out_t result,
	input wire logic cfg_we
);

	a_clear_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> (full && empty))
		else $error("input open or result present right after reset");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result changed or vanished");

	a_accept_not_dead: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.accepted) |-> !result.no_transition)
		else $error("dead string reported as accepted");

	a_no_result_early: assert property (@(posedge clk) disable iff (!arst_n)
		($past(!arst_n) && !cfg_we) |=> empty)
		else $error("result without any transaction after reset");

endmodule

bind table_driven_dfa_matcher tdm_checker u_tdm_checker (.*);

`default_nettype wire
